// ===== design/pbrgi_pkg.sv =====
`timescale 1ns / 1ps

package pbrgi_pkg;

    localparam int NUM_BINS = 4096;
    localparam int IDX_W    = $clog2(NUM_BINS);
    localparam int BIN_W    = 12;
    localparam int VAL_W    = 32;
    localparam int ACC_W    = 48;
    localparam int FR_W     = 16;
    localparam int DIV_W    = ACC_W + 1;
    localparam int DIV_STAGES = DIV_W;
    localparam int IN_W     = 96;
    localparam int OUT_W    = 2 * VAL_W;

    // configuration register indexes
    localparam logic CFG_MIN_FRAMES = 1'b0;
    localparam logic CFG_MAX_FRAMES = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [ACC_W-1:0] cur_mag;
        logic [ACC_W-1:0] cur_phase;
        logic [VAL_W-1:0] tgt_mag;
        logic [VAL_W-1:0] tgt_phase;
        logic [ACC_W-1:0] step_mag;
        logic [ACC_W-1:0] step_phase;
        logic [FR_W-1:0]  glide;
        logic [FR_W-1:0]  count;
        logic             needs;
    } bin_state_t;

    typedef struct packed {
        logic [DIV_W-1:0] num;
        logic [FR_W-1:0]  rem;
        logic             neg;
    } div_lane_t;

    typedef struct packed {
        logic       valid;
        idx_t       idx;
        bin_state_t st;
        logic [VAL_W-1:0] mag_new;
        logic [VAL_W-1:0] phase_new;
        logic [FR_W-1:0]  dur;
        div_lane_t  dm;
        div_lane_t  dp;
    } div_stage_t;

    // one restoring step: shift in the next dividend bit, subtract when it fits
    function automatic div_lane_t div_bit(div_lane_t a, logic [FR_W-1:0] d);
        logic [FR_W:0] r;
        logic          q;
        div_lane_t     o;
        begin
            o = a;
            r = {a.rem, a.num[DIV_W-1]};
            q = (r >= {1'b0, d});
            if (q)
            begin
                r = r - {1'b0, d};
            end
            o.rem = r[FR_W-1:0];
            o.num = {a.num[DIV_W-2:0], q};
            return o;
        end
    endfunction

endpackage

// ===== design/per_bin_random_glide_interpolator_top.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Signals                        | Contents (low bit up)
// ----------+-----------+--------------------------------+------------------------------------
// slave     | in        | s_tvalid s_tready s_tdata[95:0]| mag_in, phase_in, bin, random_draw
// master    | out       | m_tvalid m_tready m_tdata[63:0]| mag_out, phase_out
// config    | in        | cfg_we cfg_addr cfg_wdata[15:0]| 0: min_frames, 1: max_frames
//
// One transfer per cycle as long as the master side is not stalled and no item still
// in the pipeline shares the bin of the next one. The steps come from the
// bit-per-stage step divider.
// An item whose bin is still in flight in the pipeline waits until that bin's
// state is written back to the state memory.
// After reset a clearing pass over all NUM_BINS entries initializes the state memory;
// s_tready stays low during it. A stalled master side freezes the whole pipe.

module per_bin_random_glide_interpolator_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pbrgi_pkg::IN_W-1:0]   s_tdata,   // mag_in, phase_in, bin, random_draw, pad
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pbrgi_pkg::OUT_W-1:0]  m_tdata,   // mag_out, phase_out
    input  logic                         cfg_we,
    input  logic                         cfg_addr,
    input  logic [pbrgi_pkg::FR_W-1:0]   cfg_wdata
);
    import pbrgi_pkg::*;

    // configuration
    logic [FR_W-1:0] min_reg;
    logic [FR_W-1:0] max_reg;

    // state memory and clearing pass
    bin_state_t mem [NUM_BINS];
    bin_state_t rdata_reg;
    logic [IDX_W:0] clr_reg;
    logic           clearing;

    // stage 0: accepted item
    logic             s0_valid_reg;
    idx_t             s0_idx_reg;
    logic [VAL_W-1:0] s0_mag_reg;
    logic [VAL_W-1:0] s0_phase_reg;
    logic [FR_W-1:0]  s0_draw_reg;

    // stage 1: memory data arrives
    logic             s1_valid_reg;
    idx_t             s1_idx_reg;
    logic [VAL_W-1:0] s1_mag_reg;
    logic [VAL_W-1:0] s1_phase_reg;
    logic [FR_W-1:0]  s1_draw_reg;

    // divider pipe
    div_stage_t dv_reg [DIV_STAGES+1];
    div_stage_t dv_next [DIV_STAGES+1];

    // output register
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic       adv;
    logic       hazard;
    idx_t       in_idx;
    logic [BIN_W-1:0] in_bin;
    div_stage_t s1_next;
    bin_state_t fin;
    logic [FR_W:0] cnt;
    logic [FR_W-1:0] lo;
    logic [FR_W-1:0] hi;
    logic [2*FR_W-1:0] prod;
    logic signed [DIV_W-1:0] diff_m;
    logic signed [DIV_W-1:0] diff_p;
    logic [ACC_W-1:0] base_m;
    logic [ACC_W-1:0] base_p;
    logic [DIV_W-1:0] q_m;
    logic [DIV_W-1:0] q_p;

    assign clearing = !clr_reg[IDX_W];
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv && !clearing && !hazard;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // saturate the bin to the table
    always_comb
    begin
        in_bin = s_tdata[2*VAL_W +: BIN_W];
        if (32'(in_bin) > 32'(NUM_BINS - 1))
        begin
            in_idx = IDX_W'(NUM_BINS - 1);
        end
        else
        begin
            in_idx = IDX_W'(in_bin);
        end
    end

    // hold a new item while its bin is anywhere in flight
    always_comb
    begin
        hazard = (s0_valid_reg && s0_idx_reg == in_idx)
              || (s1_valid_reg && s1_idx_reg == in_idx);
        for (int k = 0; k <= DIV_STAGES; k++)
        begin
            if (dv_reg[k].valid && dv_reg[k].idx == in_idx)
            begin
                hazard = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= FR_W'(1);
            max_reg <= FR_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MIN_FRAMES: min_reg <= cfg_wdata;
                CFG_MAX_FRAMES: max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage 1 work: duration and the signed differences for a new target
    always_comb
    begin
        lo   = (min_reg == '0) ? FR_W'(1) : min_reg;
        hi   = (max_reg < lo) ? lo : max_reg;
        prod = s1_draw_reg * (hi - lo);
        base_m = {rdata_reg.tgt_mag, 16'h0};
        base_p = {rdata_reg.tgt_phase, 16'h0};
        diff_m = $signed({s1_mag_reg[VAL_W-1], s1_mag_reg, 16'h0})
               - $signed({base_m[ACC_W-1], base_m});
        diff_p = $signed({s1_phase_reg[VAL_W-1], s1_phase_reg, 16'h0})
               - $signed({base_p[ACC_W-1], base_p});
        s1_next.valid     = s1_valid_reg;
        s1_next.idx       = s1_idx_reg;
        s1_next.st        = rdata_reg;
        s1_next.mag_new   = s1_mag_reg;
        s1_next.phase_new = s1_phase_reg;
        s1_next.dur       = lo + prod[2*FR_W-1:FR_W];
        s1_next.dm.neg    = diff_m[DIV_W-1];
        s1_next.dm.num    = diff_m[DIV_W-1] ? DIV_W'(-diff_m) : DIV_W'(diff_m);
        s1_next.dm.rem    = '0;
        s1_next.dp.neg    = diff_p[DIV_W-1];
        s1_next.dp.num    = diff_p[DIV_W-1] ? DIV_W'(-diff_p) : DIV_W'(diff_p);
        s1_next.dp.rem    = '0;
    end

    // final stage: apply a new target when the bin needs one, advance one frame, count it
    always_comb
    begin
        fin = dv_reg[DIV_STAGES].st;
        q_m = dv_reg[DIV_STAGES].dm.neg ? -dv_reg[DIV_STAGES].dm.num
                                        : dv_reg[DIV_STAGES].dm.num;
        q_p = dv_reg[DIV_STAGES].dp.neg ? -dv_reg[DIV_STAGES].dp.num
                                        : dv_reg[DIV_STAGES].dp.num;
        if (fin.needs)
        begin
            fin.cur_mag    = {fin.tgt_mag, 16'h0};
            fin.cur_phase  = {fin.tgt_phase, 16'h0};
            fin.tgt_mag    = dv_reg[DIV_STAGES].mag_new;
            fin.tgt_phase  = dv_reg[DIV_STAGES].phase_new;
            fin.step_mag   = q_m[ACC_W-1:0];
            fin.step_phase = q_p[ACC_W-1:0];
            fin.glide      = dv_reg[DIV_STAGES].dur;
            fin.count      = '0;
        end
        fin.cur_mag   = fin.cur_mag + fin.step_mag;
        fin.cur_phase = fin.cur_phase + fin.step_phase;
        cnt = {1'b0, fin.count} + (FR_W+1)'(1);
        if (cnt >= {1'b0, fin.glide})
        begin
            fin.needs = 1'b1;
            fin.count = '0;
        end
        else
        begin
            fin.needs = 1'b0;
            fin.count = cnt[FR_W-1:0];
        end
    end

    // state memory: clearing pass, write-back, registered read
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mem[clr_reg[IDX_W-1:0]] <= '{needs: 1'b1, default: '0};
        end
        else if (adv && dv_reg[DIV_STAGES].valid)
        begin
            mem[dv_reg[DIV_STAGES].idx] <= fin;
        end
        if (adv)
        begin
            rdata_reg <= mem[s0_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clearing)
        begin
            clr_reg <= clr_reg + (IDX_W+1)'(1);
        end
    end

    // control of the front stages and output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg  <= s_tvalid && s_tready;
            s1_valid_reg  <= s0_valid_reg;
            out_valid_reg <= dv_reg[DIV_STAGES].valid;
        end
    end

    // payload of the front stages and output
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_idx_reg   <= in_idx;
            s0_mag_reg   <= s_tdata[0 +: VAL_W];
            s0_phase_reg <= s_tdata[VAL_W +: VAL_W];
            s0_draw_reg  <= s_tdata[2*VAL_W+BIN_W +: FR_W];
            s1_idx_reg   <= s0_idx_reg;
            s1_mag_reg   <= s0_mag_reg;
            s1_phase_reg <= s0_phase_reg;
            s1_draw_reg  <= s0_draw_reg;
            out_data_reg <= {fin.cur_phase[ACC_W-1:16], fin.cur_mag[ACC_W-1:16]};
        end
    end

    // divider pipe, one quotient bit per stage for both lanes
    always_comb
    begin
        dv_next[0] = s1_next;
        for (int k = 1; k <= DIV_STAGES; k++)
        begin
            dv_next[k]    = dv_reg[k-1];
            dv_next[k].dm = div_bit(dv_reg[k-1].dm, dv_reg[k-1].dur);
            dv_next[k].dp = div_bit(dv_reg[k-1].dp, dv_reg[k-1].dur);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                dv_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

endmodule

// ===== dv/pbrgi_checker.sv =====
`timescale 1ns / 1ps

module pbrgi_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [pbrgi_pkg::IN_W-1:0]   s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [pbrgi_pkg::OUT_W-1:0]  m_tdata,
    input  logic                         cfg_we,
    input  logic                         cfg_addr,
    input  logic [pbrgi_pkg::FR_W-1:0]   cfg_wdata,
    output int                           errors,
    output int                           pending
);
    import pbrgi_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] phase;
        logic [VAL_W-1:0] mag;
    } glide_out_t;

    logic [FR_W-1:0]  lo_frames, hi_frames;
    logic [ACC_W-1:0] cur_m [NUM_BINS];
    logic [ACC_W-1:0] cur_p [NUM_BINS];
    logic [VAL_W-1:0] tgt_m [NUM_BINS];
    logic [VAL_W-1:0] tgt_p [NUM_BINS];
    logic [ACC_W-1:0] stp_m [NUM_BINS];
    logic [ACC_W-1:0] stp_p [NUM_BINS];
    logic [FR_W-1:0]  glide [NUM_BINS];
    logic [FR_W-1:0]  cnt   [NUM_BINS];
    logic             need  [NUM_BINS];
    glide_out_t       glide_q [$];

    assign pending = glide_q.size();

    // truncating division of (target<<16 - current) by duration, wrapped to 48 bits
    function automatic logic [ACC_W-1:0] calc_step(logic [VAL_W-1:0] t,
                                                   logic [ACC_W-1:0] c, int unsigned d);
        longint diff;
        longint q;
        diff = (longint'($signed(t)) * 65536) - longint'($signed(c));
        q = diff / longint'(d);
        return q[ACC_W-1:0];
    endfunction

    task automatic advance_bin(logic [IN_W-1:0] d);
        logic [VAL_W-1:0] m, p;
        int unsigned b, lo, hi, dur, draw;
        glide_out_t o;
        m = d[31:0];
        p = d[63:32];
        b = d[75:64];
        draw = d[91:76];
        if (b > NUM_BINS - 1) b = NUM_BINS - 1;
        if (need[b])
        begin
            lo = (lo_frames < 1) ? 1 : lo_frames;
            hi = (hi_frames < lo) ? lo : hi_frames;
            dur = lo + ((draw * (hi - lo)) >> 16);
            cur_m[b] = {tgt_m[b], 16'h0};
            cur_p[b] = {tgt_p[b], 16'h0};
            tgt_m[b] = m;
            tgt_p[b] = p;
            glide[b] = dur[FR_W-1:0];
            stp_m[b] = calc_step(m, cur_m[b], dur);
            stp_p[b] = calc_step(p, cur_p[b], dur);
            cnt[b] = 0;
            need[b] = 1'b0;
        end
        cur_m[b] = cur_m[b] + stp_m[b];
        cur_p[b] = cur_p[b] + stp_p[b];
        o.mag = cur_m[b][47:16];
        o.phase = cur_p[b][47:16];
        glide_q.push_back(o);
        if (32'(cnt[b]) + 1 >= 32'(glide[b]))
        begin
            need[b] = 1'b1;
            cnt[b] = 0;
        end
        else
        begin
            cnt[b] = cnt[b] + 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        glide_out_t e, a;
        if (!rst_n)
        begin
            lo_frames = 1;
            hi_frames = 1;
            for (int i = 0; i < NUM_BINS; i++)
            begin
                cur_m[i] = '0; cur_p[i] = '0; tgt_m[i] = '0; tgt_p[i] = '0;
                stp_m[i] = '0; stp_p[i] = '0; glide[i] = '0; cnt[i] = '0;
                need[i] = 1'b1;
            end
            glide_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == CFG_MIN_FRAMES) lo_frames = cfg_wdata;
                else hi_frames = cfg_wdata;
            end
            if (s_tvalid && s_tready) advance_bin(s_tdata);
            if (m_tvalid && m_tready)
            begin
                a = m_tdata;
                if (glide_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none, actual %h", $time, a);
                    errors++;
                end
                else
                begin
                    e = glide_q.pop_front();
                    if (a.mag !== e.mag)
                    begin
                        $display("%0t: mag_out expected %h actual %h", $time, e.mag, a.mag);
                        errors++;
                    end
                    if (a.phase !== e.phase)
                    begin
                        $display("%0t: phase_out expected %h actual %h",
                                 $time, e.phase, a.phase);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/tb_per_bin_random_glide_interpolator_top.sv =====
`timescale 1ns / 1ps

module tb_per_bin_random_glide_interpolator_top;
    import pbrgi_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;   // mag_in, phase_in, bin, random_draw, pad
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;       // mag_out, phase_out
    logic cfg_we = 1'b0;
    logic cfg_addr = CFG_MIN_FRAMES;
    logic [FR_W-1:0] cfg_wdata = '0;
    int errors, pending;
    bit calm = 1'b0;   // no idling on either side in the closing stretch

    always #1 clk = ~clk;

    per_bin_random_glide_interpolator_top dut (.*);

    pbrgi_checker chk (.*);

    // sink side: hold tready low in random bursts
    always
    begin
        int n;
        @(posedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 15);
            m_tready <= 1'b0;
            repeat (n) @(posedge clk);
        end
        m_tready <= 1'b1;
    end

    task automatic write_reg(logic idx, logic [FR_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // present one item and hold it until the transfer happens
    task automatic send_sample(logic [31:0] m, logic [31:0] p, logic [11:0] b,
                               logic [15:0] draw);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'h0, draw, b, p, m};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DIV_STAGES + 10) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
            default: return $urandom;
        endcase
    endfunction

    // glide settings per phase: min, max, including the extremes
    logic [FR_W-1:0] mins [6] = '{16'd1, 16'd0, 16'd2, 16'd8, 16'd65535, 16'd5};
    logic [FR_W-1:0] maxs [6] = '{16'd1, 16'd4, 16'd6, 16'd3, 16'd65535, 16'd65535};

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // directed: extremes on a few bins with one-frame glides
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 12'd0, 16'h0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 12'd0, 16'hFFFF);
        send_sample(32'h0000_0000, 32'hFFFF_FFFF, 12'd4095, 16'h8000);
        send_sample(32'hFFFF_FFFF, 32'h0000_0001, 12'd4095, 16'h1234);
        send_sample(32'h0001_0000, 32'hFFFF_0000, 12'd1, 16'h0001);
        drain();
        write_reg(CFG_MIN_FRAMES, 16'd0);
        write_reg(CFG_MAX_FRAMES, 16'd7);
        for (int i = 0; i < 16; i++)
            send_sample(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, $urandom, 12'd2,
                        i[1] ? 16'hFFFF : 16'h0000);
        drain();
        // random phases; hit a small set of bins so glides run to completion
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_MIN_FRAMES, mins[ph]);
            write_reg(CFG_MAX_FRAMES, maxs[ph]);
            if (ph == 5) calm = 1'b1;
            for (int i = 0; i < 100; i++)
                send_sample(rand_val(), rand_val(),
                            ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                                       : 12'($urandom_range(0, 7)),
                            16'($urandom));
            drain();
        end
        if (errors == 0)
            $display("per_bin_random_glide_interpolator_top verification clean");
        else
            $display("per_bin_random_glide_interpolator_top verification failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("per_bin_random_glide_interpolator_top verification failed");
        $finish;
    end

endmodule
